@@ rtl/omgc_pkg.sv @@
// Shared types and constants of the offset mix, gain and clip block.
// No dependencies; every other file of the block imports this package.
package omgc_pkg;

  // Buffer geometry and entry format.
  localparam int BUFFER_DEPTH = 65536;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int ENTRY_W      = 20;
  localparam int LEN_W        = 17;
  localparam int POS_W        = 16;
  localparam int SAMPLE_W     = 16;
  localparam int GAIN_W       = 16;
  localparam int LIMIT_W      = 15;
  localparam int PROD_W       = ENTRY_W + GAIN_W + 1;
  localparam int FRAC_W       = 14;

  localparam logic [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
  localparam logic [ENTRY_W-1:0] ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};

  // Register reset values and register indexes.
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd6554;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd32735;
  localparam logic               REG_GAIN    = 1'b0;
  localparam logic               REG_LIMIT   = 1'b1;

  // Opcodes.
  localparam logic OP_MIX  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Classification of a request, decided by the front end.
  localparam logic [1:0] K_MIX  = 2'd0;
  localparam logic [1:0] K_READ = 2'd1;
  localparam logic [1:0] K_DROP = 2'd2;
  localparam logic [1:0] K_PAST = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_PAST = 2'd2;

  typedef struct packed {
    logic                       opcode;
    logic [POS_W-1:0]           offset;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clip_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic [1:0]                 status;
    logic [LEN_W-1:0]           mix_length;
  } out_item_t;

  typedef struct packed {
    logic [1:0]                 kind;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] sample;
    logic [LEN_W-1:0]           mix_length;
  } q_entry_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [LIMIT_W-1:0] clip_limit;
  } cfg_t;

endpackage

@@ rtl/omgc_front.sv @@
// Front end: accepts requests, tracks clip position and mix length, classifies.
// Depends on omgc_pkg; feeds omgc_queue.
module omgc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  omgc_pkg::in_item_t item,
  output logic              push,
  output omgc_pkg::q_entry_t entry
);
  import omgc_pkg::*;

  logic [POS_W-1:0] clip_pos_r, clip_pos_nxt;
  logic [LEN_W-1:0] mixed_len_r, mixed_len_nxt;
  logic [LEN_W-1:0] addr_sum;
  logic [LEN_W-1:0] addr_inc;
  logic             in_range;
  logic             rd_past;

  assign addr_sum = {1'b0, item.offset} + {1'b0, clip_pos_r};
  assign addr_inc = addr_sum + LEN_W'(1);
  assign in_range = 32'(addr_sum) < BUFFER_DEPTH;
  assign rd_past  = ({1'b0, item.offset} >= mixed_len_r) ||
                    (32'(item.offset) >= BUFFER_DEPTH);

  always_comb begin
    clip_pos_nxt     = clip_pos_r;
    mixed_len_nxt    = mixed_len_r;
    entry.sample     = item.sample;
    entry.addr       = ADDR_W'(addr_sum);
    entry.kind       = K_MIX;
    if (item.opcode == OP_MIX) begin
      if (in_range) begin
        if (addr_inc > mixed_len_r) begin
          mixed_len_nxt = addr_inc;
        end
      end else begin
        entry.kind = K_DROP;
      end
      clip_pos_nxt = item.clip_last ? '0 : clip_pos_r + POS_W'(1);
    end else begin
      entry.addr = ADDR_W'(item.offset);
      entry.kind = rd_past ? K_PAST : K_READ;
    end
    entry.mix_length = mixed_len_nxt;
  end

  assign push = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_pos_r  <= '0;
      mixed_len_r <= '0;
    end else if (accept) begin
      clip_pos_r  <= clip_pos_nxt;
      mixed_len_r <= mixed_len_nxt;
    end
  end

endmodule

@@ rtl/omgc_queue.sv @@
// Two-entry queue between the front end and the back end.
// Depends on omgc_pkg for the entry type.
module omgc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  omgc_pkg::q_entry_t push_entry,
  input  logic               pop,
  output omgc_pkg::q_entry_t head,
  output logic               empty,
  output logic               full
);
  import omgc_pkg::*;

  q_entry_t   slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'd2);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != 2'd3) && ((wr_ptr_r ^ rd_ptr_r) == count_r[0]))
    else $error("queue count and pointers disagree");
`endif

endmodule

@@ rtl/omgc_back.sv @@
// Back end: sample buffer with clearing pass, mix read-modify-write, gain and clip.
// Depends on omgc_pkg; takes requests from omgc_queue and drives the result port.
module omgc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  omgc_pkg::cfg_t      cfg,
  input  omgc_pkg::q_entry_t  head,
  input  logic                q_empty,
  output logic                pop,
  output logic                clearing,
  output logic                out_valid,
  output omgc_pkg::out_item_t out_data
);
  import omgc_pkg::*;

  localparam logic [1:0] B_CLEAR = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_EXEC  = 2'd2;
  localparam logic [1:0] B_SCALE = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [ENTRY_W-1:0]  mem [BUFFER_DEPTH];
  logic [ENTRY_W-1:0]  rd_data_r;
  q_entry_t            cur_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ENTRY_W-1:0] mul_a;
  logic signed [GAIN_W:0]    mul_b;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic [ENTRY_W:0]    sum;
  logic [ENTRY_W-1:0]  sat;
  logic signed [PROD_W:0]          rnd;
  logic signed [PROD_W-FRAC_W:0]   scaled;
  logic signed [PROD_W-FRAC_W:0]   lim;
  logic signed [PROD_W-FRAC_W:0]   clamped;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  // Mix: add the sign-extended sample and saturate to the entry width.
  assign sum = {rd_data_r[ENTRY_W-1], rd_data_r} +
               {{(ENTRY_W+1-SAMPLE_W){cur_r.sample[SAMPLE_W-1]}}, cur_r.sample};
  assign sat = (sum[ENTRY_W] != sum[ENTRY_W-1]) ?
               (sum[ENTRY_W] ? ENTRY_MIN : ENTRY_MAX) : sum[ENTRY_W-1:0];

  assign mul_a    = $signed(rd_data_r);
  assign mul_b    = $signed({1'b0, cfg.gain});
  assign prod_nxt = mul_a * mul_b;

  // Round half up, then an arithmetic shift gives the floor division.
  assign rnd    = $signed({prod_r[PROD_W-1], prod_r}) +
                  $signed((PROD_W+1)'(1 << (FRAC_W - 1)));
  assign scaled = rnd[PROD_W:FRAC_W];
  assign lim    = $signed({{(PROD_W-FRAC_W+1-LIMIT_W){1'b0}}, cfg.clip_limit});

  always_comb begin
    if (scaled > lim) begin
      clamped = lim;
    end else if (scaled < -lim) begin
      clamped = -lim;
    end else begin
      clamped = scaled;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_r.addr;
    mem_wdata     = sat;
    pop           = 1'b0;
    out_valid_nxt = 1'b0;
    out_data_nxt.mixed_sample = '0;
    out_data_nxt.status       = ST_OK;
    out_data_nxt.mix_length   = cur_r.mix_length;
    case (state_r)
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
        if (clr_addr_r == ADDR_W'(BUFFER_DEPTH - 1)) begin
          state_nxt = B_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          state_nxt = B_EXEC;
        end
      end
      B_EXEC: begin
        state_nxt = B_IDLE;
        case (cur_r.kind)
          K_MIX: begin
            mem_we        = 1'b1;
            out_valid_nxt = 1'b1;
          end
          K_READ: begin
            state_nxt = B_SCALE;
          end
          K_DROP: begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = ST_DROP;
          end
          K_PAST: begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = ST_PAST;
          end
          default: begin
            state_nxt = B_IDLE;
          end
        endcase
      end
      B_SCALE: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.mixed_sample = clamped[SAMPLE_W-1:0];
        state_nxt                 = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_data_r <= mem[head.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign clearing  = (state_r == B_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CLEAR) |-> (!out_valid_r && !pop))
    else $error("back end active during clearing pass");
  a_pop_exec: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == B_EXEC))
    else $error("request taken without execute step");
  a_zero_non_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != ST_OK)) |-> (out_data_r.mixed_sample == '0))
    else $error("nonzero sample on a dropped or past-length result");
  a_scale_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SCALE) |=> out_valid_r)
    else $error("read result not delivered after scaling");
`endif

endmodule

@@ rtl/offset_mix_gain_clip.sv @@
// Top level of the offset mix, gain and clip block: register port and wiring.
// Depends on omgc_pkg, omgc_front, omgc_queue and omgc_back.
//
//   Channel  Ports                                 Handshake
//   input    start, busy, in_data                  taken when start and not busy
//   result   out_valid, out_data                   one-cycle strobe, never held off
//   config   psel, penable, pwrite, paddr, pwdata,  APB, pready tied high
//            prdata, pready
//
// After reset the buffer is cleared one entry a cycle: busy stays high until all
// BUFFER_DEPTH entries (65536) are cleared. A request enters the two-entry queue
// in the cycle it is taken; the back end then reads the buffer, next does the add
// and write for a mix or the gain multiply for a read, and for a read finishes
// with rounding and clipping. busy is high while the queue is full. A result is
// registered as the back end leaves the execute step, or the scale step for a read.
module offset_mix_gain_clip (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  omgc_pkg::in_item_t  in_data,
  output logic                out_valid,
  output omgc_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import omgc_pkg::*;

  logic [GAIN_W-1:0]  gain_r;
  logic [LIMIT_W-1:0] limit_r;
  cfg_t               cfg;
  logic               accept;
  logic               push;
  q_entry_t           push_entry;
  q_entry_t           head;
  logic               pop;
  logic               q_empty;
  logic               q_full;
  logic               clearing;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_LIMIT) ? {{(32-LIMIT_W){1'b0}}, limit_r}
                                          : {{(32-GAIN_W){1'b0}}, gain_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_GAIN) begin
        gain_r <= pwdata[GAIN_W-1:0];
      end else begin
        limit_r <= pwdata[LIMIT_W-1:0];
      end
    end
  end

  assign cfg.gain       = gain_r;
  assign cfg.clip_limit = limit_r;

  assign busy   = clearing || q_full;
  assign accept = start && !busy;

  omgc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .push   (push),
    .entry  (push_entry)
  );

  omgc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  omgc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
